@@ design/block_request_prp_splitter_macros.svh @@
// assertion macros for the block request splitter
// used by block_request_prp_splitter.sv, needs nothing else
`ifndef BLOCK_REQUEST_PRP_SPLITTER_MACROS_SVH
`define BLOCK_REQUEST_PRP_SPLITTER_MACROS_SVH

// same-cycle implication
`define BPRS_ASSERT_SAME(label, clk, rstn, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define BPRS_ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ design/bprs_pkg.sv @@
// types, constants and codes for the block request splitter
// used by every module of the block, depends on nothing
`default_nettype none

package bprs_pkg;

  localparam int unsigned PADDR_W = 5;
  localparam int unsigned PDATA_W = 64;
  localparam int unsigned PAGE_W  = 17;
  localparam int unsigned BYTES_W = 18;
  localparam int unsigned COUNT_W = 6;

  localparam logic [4:0] PS_MIN = 5'd12;
  localparam logic [4:0] PS_MAX = 5'd16;
  localparam logic [3:0] BS_MIN = 4'd9;
  localparam logic [3:0] BS_MAX = 4'd12;
  localparam logic [5:0] CMD_BLOCKS_CAP     = 6'd32;
  localparam logic [5:0] MAX_REQUEST_BLOCKS = 6'd32;

  localparam logic [4:0]  PS_RESET   = 5'd12;
  localparam logic [3:0]  BS_RESET   = 4'd9;
  localparam logic [5:0]  MAXB_RESET = 6'd32;
  localparam logic [63:0] BASE_RESET = 64'd0;

  localparam logic [1:0] REG_PAGE_SHIFT  = 2'd0;
  localparam logic [1:0] REG_BLOCK_SHIFT = 2'd1;
  localparam logic [1:0] REG_MAX_BLOCKS  = 2'd2;
  localparam logic [1:0] REG_LIST_BASE   = 2'd3;

  localparam logic KIND_ENTRY = 1'b0;
  localparam logic KIND_CMD   = 1'b1;

  typedef struct packed {
    logic        req_type;
    logic [31:0] namespace_id;
    logic [63:0] start_block;
    logic [5:0]  block_count;
    logic [63:0] buffer_addr;
  } req_t;

  typedef struct packed {
    logic        item_kind;
    logic        is_write;
    logic [15:0] cmd_tag;
    logic [31:0] cmd_namespace;
    logic [63:0] cmd_start_block;
    logic [4:0]  blocks_minus_one;
    logic [63:0] first_pointer;
    logic [63:0] second_pointer;
    logic [5:0]  list_index;
    logic [63:0] entry_addr;
    logic        last;
  } res_t;

  // clamped configuration seen by the datapath
  typedef struct packed {
    logic [4:0]  page_shift;
    logic [3:0]  block_shift;
    logic [5:0]  max_blocks;
    logic [63:0] list_base;
  } cfg_t;

  typedef struct packed {
    logic load;
    logic size;
    logic split;
    logic emit_entry;
    logic emit_cmd;
  } dp_cmd_t;

  typedef struct packed {
    logic req_empty;
    logic need_list;
    logic last_entry;
    logic last_cmd;
    logic out_free;
  } dp_status_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SIZE,
    ST_SPLIT,
    ST_LIST,
    ST_CMD
  } state_e;

endpackage

`default_nettype wire

@@ design/bprs_cfg.sv @@
// configuration registers with apb-style access and clamping
// depends on bprs_pkg
`default_nettype none

module bprs_cfg (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [bprs_pkg::PADDR_W-1:0]  paddr,
  input  logic [bprs_pkg::PDATA_W-1:0]  pwdata,
  output logic [bprs_pkg::PDATA_W-1:0]  prdata,
  output logic                          pready,
  output bprs_pkg::cfg_t                cfg_o
);

  logic [4:0]  page_shift_q, page_shift_d;
  logic [3:0]  block_shift_q, block_shift_d;
  logic [5:0]  max_blocks_q, max_blocks_d;
  logic [63:0] list_base_q, list_base_d;
  logic        wr_en;
  logic [1:0]  reg_idx;
  logic [4:0]  ps_c;
  logic [3:0]  bs_c;

  assign pready  = 1'b1;
  assign wr_en   = psel && penable && pwrite && pready;
  assign reg_idx = paddr[4:3];

  always_comb begin
    page_shift_d  = page_shift_q;
    block_shift_d = block_shift_q;
    max_blocks_d  = max_blocks_q;
    list_base_d   = list_base_q;
    if (wr_en) begin
      case (reg_idx)
        bprs_pkg::REG_PAGE_SHIFT:  page_shift_d  = pwdata[4:0];
        bprs_pkg::REG_BLOCK_SHIFT: block_shift_d = pwdata[3:0];
        bprs_pkg::REG_MAX_BLOCKS:  max_blocks_d  = pwdata[5:0];
        bprs_pkg::REG_LIST_BASE:   list_base_d   = pwdata;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      page_shift_q  <= bprs_pkg::PS_RESET;
      block_shift_q <= bprs_pkg::BS_RESET;
      max_blocks_q  <= bprs_pkg::MAXB_RESET;
      list_base_q   <= bprs_pkg::BASE_RESET;
    end else begin
      page_shift_q  <= page_shift_d;
      block_shift_q <= block_shift_d;
      max_blocks_q  <= max_blocks_d;
      list_base_q   <= list_base_d;
    end
  end

  always_comb begin
    case (reg_idx)
      bprs_pkg::REG_PAGE_SHIFT:  prdata = {59'd0, page_shift_q};
      bprs_pkg::REG_BLOCK_SHIFT: prdata = {60'd0, block_shift_q};
      bprs_pkg::REG_MAX_BLOCKS:  prdata = {58'd0, max_blocks_q};
      bprs_pkg::REG_LIST_BASE:   prdata = list_base_q;
      default:                   prdata = '0;
    endcase
  end

  // clamp to legal ranges, block size never above page size
  always_comb begin
    if (page_shift_q < bprs_pkg::PS_MIN) begin
      ps_c = bprs_pkg::PS_MIN;
    end else if (page_shift_q > bprs_pkg::PS_MAX) begin
      ps_c = bprs_pkg::PS_MAX;
    end else begin
      ps_c = page_shift_q;
    end
    if (block_shift_q < bprs_pkg::BS_MIN) begin
      bs_c = bprs_pkg::BS_MIN;
    end else if (block_shift_q > bprs_pkg::BS_MAX) begin
      bs_c = bprs_pkg::BS_MAX;
    end else begin
      bs_c = block_shift_q;
    end
    if ({1'b0, bs_c} > ps_c) begin
      bs_c = ps_c[3:0];
    end
    cfg_o.page_shift  = ps_c;
    cfg_o.block_shift = bs_c;
    if (max_blocks_q == 6'd0) begin
      cfg_o.max_blocks = 6'd1;
    end else if (max_blocks_q > bprs_pkg::CMD_BLOCKS_CAP) begin
      cfg_o.max_blocks = bprs_pkg::CMD_BLOCKS_CAP;
    end else begin
      cfg_o.max_blocks = max_blocks_q;
    end
    cfg_o.list_base = list_base_q;
  end

endmodule

`default_nettype wire

@@ design/bprs_ctrl.sv @@
// sequencer for the splitter: size, split, list entries, command
// depends on bprs_pkg
`default_nettype none

module bprs_ctrl (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   in_valid_i,
  output logic                   in_ready_o,
  input  bprs_pkg::dp_status_t   status_i,
  output bprs_pkg::dp_cmd_t      cmd_o
);

  bprs_pkg::state_e state_q, state_d;

  always_comb begin
    state_d = state_q;
    case (state_q)
      bprs_pkg::ST_IDLE: begin
        if (in_valid_i && !status_i.req_empty) begin
          state_d = bprs_pkg::ST_SIZE;
        end
      end
      bprs_pkg::ST_SIZE: begin
        state_d = bprs_pkg::ST_SPLIT;
      end
      bprs_pkg::ST_SPLIT: begin
        state_d = status_i.need_list ? bprs_pkg::ST_LIST : bprs_pkg::ST_CMD;
      end
      bprs_pkg::ST_LIST: begin
        if (status_i.out_free && status_i.last_entry) begin
          state_d = bprs_pkg::ST_CMD;
        end
      end
      bprs_pkg::ST_CMD: begin
        if (status_i.out_free) begin
          state_d = status_i.last_cmd ? bprs_pkg::ST_IDLE : bprs_pkg::ST_SIZE;
        end
      end
      default: state_d = bprs_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready_o       = 1'b0;
    cmd_o            = '0;
    case (state_q)
      bprs_pkg::ST_IDLE: begin
        in_ready_o = 1'b1;
        cmd_o.load = in_valid_i;
      end
      bprs_pkg::ST_SIZE:  cmd_o.size       = 1'b1;
      bprs_pkg::ST_SPLIT: cmd_o.split      = 1'b1;
      bprs_pkg::ST_LIST:  cmd_o.emit_entry = status_i.out_free;
      bprs_pkg::ST_CMD:   cmd_o.emit_cmd   = status_i.out_free;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= bprs_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

`default_nettype wire

@@ design/bprs_datapath.sv @@
// request registers, chunk sizing, page split and output register
// depends on bprs_pkg
`default_nettype none

module bprs_datapath (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  bprs_pkg::req_t         in_data_i,
  input  bprs_pkg::cfg_t         cfg_i,
  input  bprs_pkg::dp_cmd_t      cmd_i,
  output bprs_pkg::dp_status_t   status_o,
  input  logic                   out_ready_i,
  output logic                   out_valid_o,
  output bprs_pkg::res_t         out_data_o
);

  logic                          is_wr_q;
  logic [31:0]                   nsid_q;
  logic [63:0]                   lba_q;
  logic [5:0]                    remaining_q;
  logic [63:0]                   addr_q;
  logic [5:0]                    blocks_q;
  logic [bprs_pkg::BYTES_W-1:0]  bytes_q;
  logic [bprs_pkg::PAGE_W-1:0]   room_q;
  logic [63:0]                   second_q;
  logic [63:0]                   next_q;
  logic [5:0]                    pages_q;
  logic [5:0]                    idx_q;
  logic [15:0]                   cmd_id_q;
  logic                          out_valid_q;
  bprs_pkg::res_t                out_q;

  logic [bprs_pkg::PAGE_W-1:0]   page;
  logic [bprs_pkg::PAGE_W-1:0]   page_mask;
  logic [5:0]                    count_c;
  logic [5:0]                    blocks_c;
  logic [bprs_pkg::BYTES_W-1:0]  bytes_c;
  logic [bprs_pkg::PAGE_W-1:0]   room_c;
  logic                          over_c;
  logic [bprs_pkg::BYTES_W-1:0]  rest_c;
  logic [63:0]                   next_c;
  logic                          list_c;
  logic [bprs_pkg::BYTES_W:0]    round_c;
  logic [5:0]                    pages_c;
  logic [63:0]                   second_c;
  logic                          out_free;
  logic                          last_cmd;
  bprs_pkg::res_t                res_c;

  assign page      = bprs_pkg::PAGE_W'(1) << cfg_i.page_shift;
  assign page_mask = page - bprs_pkg::PAGE_W'(1);

  assign count_c = (in_data_i.block_count > bprs_pkg::MAX_REQUEST_BLOCKS) ?
                   bprs_pkg::MAX_REQUEST_BLOCKS : in_data_i.block_count;

  // chunk size and room left in the current page
  assign blocks_c = (remaining_q < cfg_i.max_blocks) ? remaining_q : cfg_i.max_blocks;
  assign bytes_c  = bprs_pkg::BYTES_W'(blocks_c) << cfg_i.block_shift;
  assign room_c   = page - {1'b0, addr_q[15:0] & page_mask[15:0]};

  // second pointer selection
  assign over_c  = bytes_q > bprs_pkg::BYTES_W'(room_q);
  assign rest_c  = bytes_q - bprs_pkg::BYTES_W'(room_q);
  assign next_c  = addr_q + 64'(room_q);
  assign list_c  = over_c && (rest_c > bprs_pkg::BYTES_W'(page));
  assign round_c = (bprs_pkg::BYTES_W+1)'(rest_c) + (bprs_pkg::BYTES_W+1)'(page_mask);
  assign pages_c = bprs_pkg::COUNT_W'(round_c >> cfg_i.page_shift);

  always_comb begin
    if (!over_c) begin
      second_c = '0;
    end else if (!list_c) begin
      second_c = next_c;
    end else begin
      second_c = cfg_i.list_base;
    end
  end

  assign out_free = !out_valid_q || out_ready_i;
  assign last_cmd = remaining_q == blocks_q;

  assign status_o.req_empty  = in_data_i.block_count == 6'd0;
  assign status_o.need_list  = list_c;
  assign status_o.last_entry = idx_q == (pages_q - 6'd1);
  assign status_o.last_cmd   = last_cmd;
  assign status_o.out_free   = out_free;

  always_comb begin
    res_c = '0;
    if (cmd_i.emit_entry) begin
      res_c.item_kind  = bprs_pkg::KIND_ENTRY;
      res_c.list_index = idx_q;
      res_c.entry_addr = next_q;
    end else begin
      res_c.item_kind        = bprs_pkg::KIND_CMD;
      res_c.is_write         = is_wr_q;
      res_c.cmd_tag          = cmd_id_q;
      res_c.cmd_namespace    = nsid_q;
      res_c.cmd_start_block  = lba_q;
      res_c.blocks_minus_one = 5'(blocks_q - 6'd1);
      res_c.first_pointer    = addr_q;
      res_c.second_pointer   = second_q;
      res_c.last             = last_cmd;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      cmd_id_q    <= '0;
    end else begin
      if (cmd_i.emit_entry || cmd_i.emit_cmd) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      if (cmd_i.emit_cmd) begin
        cmd_id_q <= cmd_id_q + 16'd1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      is_wr_q     <= in_data_i.req_type;
      nsid_q      <= in_data_i.namespace_id;
      lba_q       <= in_data_i.start_block;
      remaining_q <= count_c;
      addr_q      <= in_data_i.buffer_addr;
    end
    if (cmd_i.size) begin
      blocks_q <= blocks_c;
      bytes_q  <= bytes_c;
      room_q   <= room_c;
    end
    if (cmd_i.split) begin
      second_q <= second_c;
      next_q   <= next_c;
      pages_q  <= pages_c;
      idx_q    <= '0;
    end
    if (cmd_i.emit_entry) begin
      next_q <= next_q + 64'(page);
      idx_q  <= idx_q + 6'd1;
    end
    if (cmd_i.emit_cmd) begin
      lba_q       <= lba_q + 64'(blocks_q);
      addr_q      <= addr_q + 64'(bytes_q);
      remaining_q <= remaining_q - blocks_q;
    end
    if (cmd_i.emit_entry || cmd_i.emit_cmd) begin
      out_q <= res_c;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

`default_nettype wire

@@ design/block_request_prp_splitter.sv @@
// top level of the block request splitter
// depends on bprs_pkg, bprs_cfg, bprs_ctrl, bprs_datapath and the macros header
//
//   channel   direction  handshake            word
//   in        input      in_valid/in_ready    bprs_pkg::req_t, one request
//   out       output     out_valid/out_ready  bprs_pkg::res_t, list entry or command
//   cfg       input      apb psel/penable     64-bit register write or read
//
// a request is accepted while idle, then each command goes through size, split, any list entries and emit
// requests are taken one at a time; in_ready is high only while the sequencer is idle
// a zero block count is accepted while idle and gives no word
// out_ready low with a word held holds the sequencer in its emit step; the output register frees the input
// reset loads default configuration and clears the command id, no clearing pass
`default_nettype none
`include "block_request_prp_splitter_macros.svh"

module block_request_prp_splitter (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  bprs_pkg::req_t                in_data_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output bprs_pkg::res_t                out_data_o,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [bprs_pkg::PADDR_W-1:0]  paddr,
  input  logic [bprs_pkg::PDATA_W-1:0]  pwdata,
  output logic [bprs_pkg::PDATA_W-1:0]  prdata,
  output logic                          pready
);

  bprs_pkg::cfg_t        cfg;
  bprs_pkg::dp_cmd_t     dp_cmd;
  bprs_pkg::dp_status_t  dp_status;

  bprs_cfg u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  bprs_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .status_i   (dp_status),
    .cmd_o      (dp_cmd)
  );

  bprs_datapath u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_data_i   (in_data_i),
    .cfg_i       (cfg),
    .cmd_i       (dp_cmd),
    .status_o    (dp_status),
    .out_ready_i (out_ready_i),
    .out_valid_o (out_valid_o),
    .out_data_o  (out_data_o)
  );

  `BPRS_ASSERT_NEXT(a_busy_after_accept, clk_i, rst_ni, in_valid_i && in_ready_o && (in_data_i.block_count != 6'd0), !in_ready_o, "nonempty request did not start")
  `BPRS_ASSERT_SAME(a_entry_not_last, clk_i, rst_ni, out_valid_o && (out_data_o.item_kind == bprs_pkg::KIND_ENTRY), !out_data_o.last, "list entry marked last")
  `BPRS_ASSERT_SAME(a_busy_until_last, clk_i, rst_ni, out_valid_o && !out_data_o.last, !in_ready_o, "idle before last word")

endmodule

`default_nettype wire
